// ===== hdl/c3x3_pkg.sv =====
package c3x3_pkg;

  localparam int MaxWidth = 1024;
  localparam int ColW     = $clog2(MaxWidth);

  localparam logic [2:0] CfgWidth   = 3'd0;
  localparam logic [2:0] CfgHeight  = 3'd1;
  localparam logic [2:0] CfgKernTop = 3'd2;
  localparam logic [2:0] CfgKernMid = 3'd3;
  localparam logic [2:0] CfgKernBot = 3'd4;
  localparam logic [2:0] CfgDivider = 3'd5;
  localparam logic [2:0] CfgOffset  = 3'd6;

  typedef logic [31:0] pix_t;
  typedef pix_t [2:0][2:0] window_t;

  typedef struct packed {
    logic [10:0]       width;
    logic [15:0]       height;
    logic [2:0][23:0]  kern;
    logic [15:0]       divider;
    logic signed [8:0] offset;
  } cfg_t;

  typedef struct packed {
    logic       emit;
    logic       last;
    logic [8:0] mask;
  } tap_ctrl_t;

  typedef struct packed {
    logic             valid;
    logic             last;
    logic [7:0]       alpha;
    logic [2:0][25:0] num;
  } mac_out_t;

  typedef struct packed {
    logic            last;
    logic [7:0]      alpha;
    logic [2:0][7:0] chan;
  } res_t;

  typedef struct packed {
    logic             valid;
    logic             last;
    logic [7:0]       alpha;
    logic [2:0]       zero;
    logic [2:0]       full;
    logic [2:0][24:0] rem;
    logic [2:0][7:0]  quo;
  } div_stage_t;

endpackage

// ===== hdl/conv3x3_rgb_zero_pad.sv =====
// 3x3 convolution over a BGRA raster stream with zero padding. One beat is taken per clock
// unless the output buffer is full and stalled, pixels and flush beats alike; the result for
// a pixel comes out one row plus one pixel of beats later, and tvalid rises once that result
// has passed the pipeline into the output buffer. The sustained rate of one beat per cycle
// is set by the single line-store RAM (1024 x 64, one read and one write port per cycle) and
// by the pipelined window, multiply, sum and 8-stage restoring divider. A 2-entry output
// buffer lets input keep flowing while the output is stalled, until both entries are full.
// Send frame_width + 1 flush beats after the last pixel to drain the frame. The line store
// needs no clearing after reset. Configuration must be written only while the block is idle.
module conv3x3_rgb_zero_pad import c3x3_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // in_blue, in_green, in_red, in_alpha
  input  logic        s_axis_tuser,   // kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // out_blue, out_green, out_red, out_alpha
  output logic        m_axis_tlast    // last_of_frame
);

  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width   <= 11'(MaxWidth);
      cfg_q.height  <= 16'd1;
      cfg_q.kern    <= {24'd0, 24'h000100, 24'd0};
      cfg_q.divider <= 16'd1;
      cfg_q.offset  <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgWidth: begin
          if (cfg_data_i[10:0] == '0) cfg_q.width <= 11'd1;
          else if (cfg_data_i[10:0] > 11'(MaxWidth)) cfg_q.width <= 11'(MaxWidth);
          else cfg_q.width <= cfg_data_i[10:0];
        end
        CfgHeight:  cfg_q.height  <= (cfg_data_i[15:0] == '0) ? 16'd1 : cfg_data_i[15:0];
        CfgKernTop: cfg_q.kern[2] <= cfg_data_i;
        CfgKernMid: cfg_q.kern[1] <= cfg_data_i;
        CfgKernBot: cfg_q.kern[0] <= cfg_data_i;
        CfgDivider: cfg_q.divider <= (cfg_data_i[15:0] == '0) ? 16'd1 : cfg_data_i[15:0];
        CfgOffset:  cfg_q.offset  <= $signed(cfg_data_i[8:0]);
        default: ;
      endcase
    end
  end

  logic      en, in_fire, line_v, div_v, push, pop;
  tap_ctrl_t line_ctrl;
  window_t   win;
  mac_out_t  mac;
  res_t      res, ent0_q, ent1_q;
  logic [1:0] cnt_q;

  assign en            = (cnt_q != 2'd2) || m_axis_tready;
  assign s_axis_tready = en;
  assign in_fire       = s_axis_tvalid & en;

  c3x3_line u_line (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .cfg_i     (cfg_q),
    .in_fire_i (in_fire),
    .in_kind_i (s_axis_tuser),
    .in_pix_i  (s_axis_tdata),
    .valid_o   (line_v),
    .ctrl_o    (line_ctrl),
    .win_o     (win)
  );

  c3x3_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .cfg_i   (cfg_q),
    .valid_i (line_v),
    .ctrl_i  (line_ctrl),
    .win_i   (win),
    .mac_o   (mac)
  );

  c3x3_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .divider_i (cfg_q.divider),
    .mac_i     (mac),
    .valid_o   (div_v),
    .res_o     (res)
  );

  // output buffer, two entries
  assign push = en & div_v;
  assign pop  = m_axis_tvalid & m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      ent0_q <= (cnt_q == 2'd2) ? ent1_q : res;
    end else if (push && cnt_q == 2'd0) begin
      ent0_q <= res;
    end
    if (push && ((cnt_q == 2'd1 && !pop) || (cnt_q == 2'd2 && pop))) begin
      ent1_q <= res;
    end
  end

  assign m_axis_tvalid = cnt_q != 2'd0;
  assign m_axis_tdata  = {ent0_q.alpha, ent0_q.chan[2], ent0_q.chan[1], ent0_q.chan[0]};
  assign m_axis_tlast  = ent0_q.last;

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with empty output buffer");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("output buffer overflow");

  a_push_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> m_axis_tvalid)
    else $error("pushed result not presented");

endmodule

// ===== hdl/c3x3_ram.sv =====
module c3x3_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ===== hdl/c3x3_line.sv =====
module c3x3_line import c3x3_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  cfg_t        cfg_i,
  input  logic        in_fire_i,
  input  logic        in_kind_i,
  input  pix_t        in_pix_i,
  output logic        valid_o,
  output tap_ctrl_t   ctrl_o,
  output window_t     win_o
);

  logic [ColW-1:0] in_col_q, in_col_d, out_col_q, out_col_d;
  logic [15:0]     in_row_q, in_row_d, out_row_q, out_row_d;
  tap_ctrl_t       ctrl;
  logic [2:0]      rmask, cmask;

  always_comb begin
    ctrl.emit = (in_row_q >= 16'd2) || (in_row_q == 16'd1 && in_col_q != '0);
    ctrl.last = ({1'b0, out_row_q} + 17'd1 >= {1'b0, cfg_i.height}) &&
                ({1'b0, out_col_q} + 11'd1 >= cfg_i.width);
    rmask[0] = out_row_q != '0;
    rmask[1] = out_row_q < cfg_i.height;
    rmask[2] = ({1'b0, out_row_q} + 17'd1) < {1'b0, cfg_i.height};
    cmask[0] = out_col_q != '0;
    cmask[1] = {1'b0, out_col_q} < cfg_i.width;
    cmask[2] = ({1'b0, out_col_q} + 11'd1) < cfg_i.width;
    for (int i = 0; i < 9; i++) begin
      ctrl.mask[i] = rmask[i / 3] & cmask[i % 3];
    end

    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    if ({1'b0, in_col_q} + 11'd1 >= cfg_i.width) begin
      in_col_d = '0;
      if (in_row_q != 16'hFFFF) in_row_d = in_row_q + 16'd1;
    end else begin
      in_col_d = in_col_q + 1'b1;
    end
    if (ctrl.emit) begin
      if (ctrl.last) begin
        in_col_d  = '0;
        in_row_d  = '0;
        out_col_d = '0;
        out_row_d = '0;
      end else if ({1'b0, out_col_q} + 11'd1 >= cfg_i.width) begin
        out_col_d = '0;
        if (out_row_q != 16'hFFFF) out_row_d = out_row_q + 16'd1;
      end else begin
        out_col_d = out_col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else if (in_fire_i) begin
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
    end
  end

  // stage 1: line store read returns
  logic            s1_v_q;
  pix_t            s1_pix_q;
  logic [ColW-1:0] s1_idx_q;
  tap_ctrl_t       s1_ctrl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (en_i) begin
      s1_v_q <= in_fire_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_pix_q  <= in_kind_i ? '0 : in_pix_i;
      s1_idx_q  <= in_col_q;
      s1_ctrl_q <= ctrl;
    end
  end

  // word: middle line in the upper half, upper line in the lower half
  logic [63:0]     rdata, wdata, line_word;
  logic            fwd_v_q;
  logic [ColW-1:0] fwd_idx_q;
  logic [63:0]     fwd_data_q;

  assign line_word = (fwd_v_q && fwd_idx_q == s1_idx_q) ? fwd_data_q : rdata;
  assign wdata     = {s1_pix_q, line_word[63:32]};

  c3x3_ram #(
    .Width (64),
    .Depth (MaxWidth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (en_i & s1_v_q),
    .waddr_i (s1_idx_q),
    .wdata_i (wdata),
    .re_i    (en_i),
    .raddr_i (in_col_q),
    .rdata_o (rdata)
  );

  // write of the previous beat, missed by the read issued alongside it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_v_q <= 1'b0;
    end else if (en_i) begin
      fwd_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fwd_idx_q  <= s1_idx_q;
      fwd_data_q <= wdata;
    end
  end

  // stage 2: window
  window_t   win_q;
  logic      s2_v_q;
  tap_ctrl_t s2_ctrl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q  <= '0;
      s2_v_q <= 1'b0;
    end else if (en_i) begin
      s2_v_q <= s1_v_q & s1_ctrl_q.emit;
      if (s1_v_q) begin
        for (int r = 0; r < 3; r++) begin
          win_q[r][0] <= win_q[r][1];
          win_q[r][1] <= win_q[r][2];
        end
        win_q[0][2] <= line_word[31:0];
        win_q[1][2] <= line_word[63:32];
        win_q[2][2] <= s1_pix_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_ctrl_q <= s1_ctrl_q;
    end
  end

  assign valid_o = s2_v_q;
  assign ctrl_o  = s2_ctrl_q;
  assign win_o   = win_q;

endmodule

// ===== hdl/c3x3_mac.sv =====
module c3x3_mac import c3x3_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  cfg_t      cfg_i,
  input  logic      valid_i,
  input  tap_ctrl_t ctrl_i,
  input  window_t   win_i,
  output mac_out_t  mac_o
);

  logic signed [16:0] prod_d [9][3];
  logic signed [16:0] prod_q [9][3];
  logic signed [7:0]  coef;
  logic               m1_v_q, m1_last_q, m2_v_q, m2_last_q, m3_v_q, m3_last_q;
  logic [7:0]         m1_alpha_q, m2_alpha_q, m3_alpha_q;
  logic signed [20:0] sum_d [3];
  logic signed [20:0] sum_q [3];
  logic signed [25:0] offdiv_q;
  logic [2:0][25:0]   num_q;

  always_comb begin
    for (int t = 0; t < 9; t++) begin
      coef = $signed(cfg_i.kern[2 - t / 3][8 * (t % 3) +: 8]);
      for (int ch = 0; ch < 3; ch++) begin
        prod_d[t][ch] = ctrl_i.mask[t] ?
                        $signed({1'b0, win_i[t / 3][t % 3][8 * ch +: 8]}) * coef :
                        17'sd0;
      end
    end
    for (int ch = 0; ch < 3; ch++) begin
      sum_d[ch] = '0;
      for (int t = 0; t < 9; t++) begin
        sum_d[ch] = sum_d[ch] + 21'(prod_q[t][ch]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_v_q <= 1'b0;
      m2_v_q <= 1'b0;
      m3_v_q <= 1'b0;
    end else if (en_i) begin
      m1_v_q <= valid_i;
      m2_v_q <= m1_v_q;
      m3_v_q <= m2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    offdiv_q <= cfg_i.offset * $signed({1'b0, cfg_i.divider});
    if (en_i) begin
      prod_q     <= prod_d;
      m1_last_q  <= ctrl_i.last;
      m1_alpha_q <= win_i[1][1][31:24];
      sum_q      <= sum_d;
      m2_last_q  <= m1_last_q;
      m2_alpha_q <= m1_alpha_q;
      for (int ch = 0; ch < 3; ch++) begin
        num_q[ch] <= 26'(sum_q[ch]) + offdiv_q;
      end
      m3_last_q  <= m2_last_q;
      m3_alpha_q <= m2_alpha_q;
    end
  end

  assign mac_o.valid = m3_v_q;
  assign mac_o.last  = m3_last_q;
  assign mac_o.alpha = m3_alpha_q;
  assign mac_o.num   = num_q;

endmodule

// ===== hdl/c3x3_div.sv =====
module c3x3_div import c3x3_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic [15:0] divider_i,
  input  mac_out_t    mac_i,
  output logic        valid_o,
  output res_t        res_o
);

  div_stage_t st_q [9];
  div_stage_t st_d [9];
  logic [24:0] dsh;

  always_comb begin
    st_d[0].valid = mac_i.valid;
    st_d[0].last  = mac_i.last;
    st_d[0].alpha = mac_i.alpha;
    st_d[0].quo   = '0;
    for (int ch = 0; ch < 3; ch++) begin
      st_d[0].zero[ch] = mac_i.num[ch][25];
      st_d[0].full[ch] = !mac_i.num[ch][25] &&
                         (mac_i.num[ch][24:0] >= {1'b0, divider_i, 8'd0});
      st_d[0].rem[ch]  = mac_i.num[ch][24:0];
    end
    // one quotient bit per stage, most significant first
    for (int s = 1; s < 9; s++) begin
      st_d[s] = st_q[s - 1];
      dsh     = {9'd0, divider_i} << (8 - s);
      for (int ch = 0; ch < 3; ch++) begin
        if (!st_q[s - 1].zero[ch] && !st_q[s - 1].full[ch] &&
            st_q[s - 1].rem[ch] >= dsh) begin
          st_d[s].rem[ch]       = st_q[s - 1].rem[ch] - dsh;
          st_d[s].quo[ch][8 - s] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < 9; s++) begin
        st_q[s] <= '0;
      end
    end else if (en_i) begin
      st_q <= st_d;
    end
  end

  always_comb begin
    res_o.last  = st_q[8].last;
    res_o.alpha = st_q[8].alpha;
    for (int ch = 0; ch < 3; ch++) begin
      if (st_q[8].zero[ch]) begin
        res_o.chan[ch] = 8'd0;
      end else if (st_q[8].full[ch]) begin
        res_o.chan[ch] = 8'd255;
      end else begin
        res_o.chan[ch] = st_q[8].quo[ch];
      end
    end
  end

  assign valid_o = st_q[8].valid;

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps

module tb import c3x3_pkg::*;;

  typedef struct packed {
    logic       last;
    logic [7:0] alpha;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } px_res_t;

  typedef struct {
    logic        kind;
    logic [31:0] data;
    logic        has_gold;
    px_res_t     gold;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [23:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tlast;

  conv3x3_rgb_zero_pad dut (.*);

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [10:0] m_width;
  logic [15:0] m_height;
  logic [23:0] m_kern [3];
  logic [15:0] m_div;
  logic signed [8:0] m_off;
  logic [31:0] upper_row [MaxWidth];
  logic [31:0] mid_row [MaxWidth];
  logic [31:0] win [3][3];
  int unsigned in_col, in_row, out_col, out_row;

  px_res_t pending_px[$];
  int     errors = 0;
  int     src_idle_pct = 0, snk_idle_pct = 0;
  bit     hold_sink = 1'b0;

  function automatic int unsigned eff_w();
    if (m_width == 0) return 1;
    if (m_width > MaxWidth) return MaxWidth;
    return m_width;
  endfunction

  function automatic int unsigned eff_h();
    return (m_height == 0) ? 1 : m_height;
  endfunction

  function automatic logic [7:0] finish_chan(int sum);
    longint dv, q;
    dv = (m_div == 0) ? 1 : m_div;
    q = (longint'(sum) + longint'(m_off) * dv) / dv;
    if (q > 255) q = 255;
    if (q < 0) q = 0;
    return q[7:0];
  endfunction

  task automatic conv_step(input logic kind, input logic [31:0] data);
    int unsigned w, h, idx;
    logic [31:0] pix;
    bit emit;
    int sb, sg, sr, k, tr, tc;
    px_res_t r;
    w = eff_w();
    h = eff_h();
    pix = kind ? 32'd0 : data;
    idx = (in_col < MaxWidth) ? in_col : MaxWidth - 1;
    emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);
    for (int i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = upper_row[idx];
    win[1][2] = mid_row[idx];
    win[2][2] = pix;
    upper_row[idx] = mid_row[idx];
    mid_row[idx] = pix;
    if (in_col + 1 >= w) begin
      in_col = 0;
      if (in_row < 16'hFFFF) in_row++;
    end else begin
      in_col++;
    end
    if (!emit) return;
    sb = 0; sg = 0; sr = 0;
    for (int i = 0; i < 3; i++) begin
      tr = int'(out_row) + i - 1;
      if (tr < 0 || tr >= int'(h)) continue;
      for (int j = 0; j < 3; j++) begin
        tc = int'(out_col) + j - 1;
        if (tc < 0 || tc >= int'(w)) continue;
        k = $signed(m_kern[i][8*j +: 8]);
        sb += int'(win[i][j][7:0]) * k;
        sg += int'(win[i][j][15:8]) * k;
        sr += int'(win[i][j][23:16]) * k;
      end
    end
    r.last = (out_row + 1 >= h) && (out_col + 1 >= w);
    r.blue = finish_chan(sb);
    r.green = finish_chan(sg);
    r.red = finish_chan(sr);
    r.alpha = win[1][1][31:24];
    pending_px.push_back(r);
    if (r.last) begin
      in_col = 0; in_row = 0; out_col = 0; out_row = 0;
    end else if (out_col + 1 >= w) begin
      out_col = 0;
      if (out_row < 16'hFFFF) out_row++;
    end else begin
      out_col++;
    end
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CfgWidth:   m_width = val[10:0];
      CfgHeight:  m_height = val[15:0];
      CfgKernTop: m_kern[0] = val;
      CfgKernMid: m_kern[1] = val;
      CfgKernBot: m_kern[2] = val;
      CfgDivider: m_div = val[15:0];
      CfgOffset:  m_off = val[8:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic setup(input int w, input int h, input logic [23:0] kt, input logic [23:0] km,
                       input logic [23:0] kb, input int dv, input int off);
    write_reg(CfgWidth, 24'(w));
    write_reg(CfgHeight, 24'(h));
    write_reg(CfgKernTop, kt);
    write_reg(CfgKernMid, km);
    write_reg(CfgKernBot, kb);
    write_reg(CfgDivider, 24'(dv));
    write_reg(CfgOffset, 24'(off & 9'h1FF));
  endtask

  task automatic drain();
    while (pending_px.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  // drives one beat; the model steps on acceptance
  task automatic send_px(input logic kind, input logic [31:0] data);
    @(negedge clk_i);
    while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= data;
    do @(posedge clk_i); while (!s_axis_tready);
    conv_step(kind, data);
  endtask

  task automatic send_frame(input int w, input int h, input bit noisy);
    for (int i = 0; i < w * h; i++)
      send_px(noisy && $urandom_range(15) == 0, $urandom);
    if (noisy && $urandom_range(3) == 0)
      repeat ($urandom_range(1, 3)) send_px(1'b0, $urandom);
    while (in_row != 0 || in_col != 0 || out_row != 0 || out_col != 0)
      send_px(1'b1, $urandom);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic rand_setup(output int w, output int h);
    logic [23:0] kt, km, kb;
    int dv, off;
    w = ($urandom_range(9) == 0) ? $urandom_range(30, 64) : $urandom_range(1, 8);
    h = $urandom_range(1, 6);
    case ($urandom_range(3))
      0: begin kt = 24'h010201; km = 24'h020402; kb = 24'h010201; dv = 16; end
      1: begin kt = 24'h010101; km = 24'h010101; kb = 24'h010101; dv = 9; end
      2: begin kt = 24'hFFFFFF; km = 24'hFF08FF; kb = 24'hFFFFFF; dv = 1; end
      default: begin
        kt = $urandom; km = $urandom; kb = $urandom;
        dv = ($urandom_range(3) == 0) ? $urandom_range(0, 65535) : $urandom_range(1, 40);
      end
    endcase
    off = $urandom_range(0, 3) == 0 ? int'($urandom_range(0, 510)) - 255 : 0;
    setup(w, h, kt, km, kb, dv, off);
  endtask

  // sink
  initial begin
    px_res_t got, want;
    forever begin
      @(negedge clk_i);
      m_axis_tready <= !hold_sink &&
                       !(snk_idle_pct != 0 && $urandom_range(99) < snk_idle_pct);
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tlast, m_axis_tdata[31:24], m_axis_tdata[23:16],
               m_axis_tdata[15:8], m_axis_tdata[7:0]};
        if (pending_px.size() == 0) begin
          $error("unexpected beat %h", got);
          errors++;
        end else begin
          want = pending_px.pop_front();
          if (got.blue !== want.blue) begin
            $error("out_blue exp %0d got %0d", want.blue, got.blue); errors++;
          end
          if (got.green !== want.green) begin
            $error("out_green exp %0d got %0d", want.green, got.green); errors++;
          end
          if (got.red !== want.red) begin
            $error("out_red exp %0d got %0d", want.red, got.red); errors++;
          end
          if (got.alpha !== want.alpha) begin
            $error("out_alpha exp %0d got %0d", want.alpha, got.alpha); errors++;
          end
          if (got.last !== want.last) begin
            $error("last_of_frame exp %0d got %0d", want.last, got.last); errors++;
          end
        end
      end
    end
  end

  initial begin
    #100ms;
    $display("tb: FAIL");
    $finish;
  end

  initial begin
    dir_row_t rows[$];
    dir_row_t row;
    px_res_t gold;
    int w, h, sent;
    m_width = 1024; m_height = 1;
    m_kern[0] = 0; m_kern[1] = 24'h000100; m_kern[2] = 0;
    m_div = 1; m_off = 0;
    for (int i = 0; i < MaxWidth; i++) begin
      upper_row[i] = 0; mid_row[i] = 0;
    end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) win[i][j] = 0;
    in_col = 0; in_row = 0; out_col = 0; out_row = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // 1x1 frames with the reset identity kernel except width: results read off directly
    write_reg(CfgWidth, 24'd1);
    rows.push_back('{1'b0, 32'hFFFFFFFF, 1'b0, '0});
    rows.push_back('{1'b1, 32'h0, 1'b0, '0});
    rows.push_back('{1'b1, 32'h0, 1'b1, px_res_t'({1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF})});
    rows.push_back('{1'b0, 32'h00000000, 1'b0, '0});
    rows.push_back('{1'b1, 32'h0, 1'b0, '0});
    rows.push_back('{1'b1, 32'h0, 1'b1, px_res_t'({1'b1, 8'h00, 8'h00, 8'h00, 8'h00})});
    rows.push_back('{1'b0, 32'h80402010, 1'b0, '0});
    rows.push_back('{1'b1, 32'h0, 1'b0, '0});
    rows.push_back('{1'b1, 32'h0, 1'b1, px_res_t'({1'b1, 8'h80, 8'h40, 8'h20, 8'h10})});
    rows.push_back('{1'b1, 32'h12345678, 1'b0, '0});
    rows.push_back('{1'b1, 32'h0, 1'b0, '0});
    rows.push_back('{1'b1, 32'h0, 1'b1, px_res_t'({1'b1, 8'h00, 8'h00, 8'h00, 8'h00})});
    foreach (rows[i]) begin
      row = rows[i];
      send_px(row.kind, row.data);
      if (row.has_gold) begin
        gold = pending_px[$];
        if (gold != row.gold) begin
          $error("table row %0d exp %h got %h", i, row.gold, gold); errors++;
        end
      end
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    drain();

    // extremes of the registers, early flush and extra pixels on small frames
    setup(3, 2, 24'h7F7F7F, 24'h7F7F7F, 24'h7F7F7F, 1, 255);
    send_frame(3, 2, 1'b1);
    drain();
    setup(2, 2, 24'h808080, 24'h808080, 24'h808080, 65535, -255);
    send_frame(2, 2, 1'b1);
    drain();
    setup(0, 0, 24'hFFFFFF, 24'h010101, 24'h000000, 0, 0);
    send_frame(1, 1, 1'b0);
    drain();

    // back-pressure: sink holds off long while the source keeps offering
    setup(4, 3, 24'h010201, 24'h020402, 24'h010201, 16, 0);
    fork
      send_frame(4, 3, 1'b0);
      begin
        hold_sink = 1'b1;
        repeat (300) @(posedge clk_i);
        hold_sink = 1'b0;
      end
    join
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      src_idle_pct = (ph == 0) ? 33 : (ph == 1) ? 52 : 0;
      snk_idle_pct = (ph == 0) ? 52 : (ph == 1) ? 33 : 0;
      sent = 0;
      while (sent < 350) begin
        rand_setup(w, h);
        send_frame(eff_w(), eff_h(), $urandom_range(4) == 0);
        sent += eff_w() * eff_h() + eff_w() + 1;
        drain();
      end
    end

    if (errors == 0 && pending_px.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
